>>> hdl/gspd_pkg.sv
// Shared types and constants for the gap-split pulse train decoder.
// Used by the channel interfaces, the key encoder, the top level and the checker.
`default_nettype none

package gspd_pkg;

  localparam int REG_BITS    = 24;
  localparam int CFG_IDX_BITS = 2;
  localparam int LETTER_BITS = 8;
  localparam int DIGIT_BITS  = 4;

  localparam logic [REG_BITS-1:0] JITTER_RESET   = 24'd10000;
  localparam logic [REG_BITS-1:0] GAP_RESET      = 24'd250000;
  localparam logic [REG_BITS-1:0] BOUNDARY_RESET = 24'd400000;

  localparam int LETTER_BASE  = 65;
  localparam int LETTER_SKIP  = 72;
  localparam int LETTER_MAX   = 255;
  localparam int DIGIT_RADIX  = 10;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_JITTER   = 2'd0,
    CFG_GAP      = 2'd1,
    CFG_BOUNDARY = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [LETTER_BITS-1:0] letter_code;
    logic [DIGIT_BITS-1:0]  digit;
  } key_t;

endpackage

`default_nettype wire

>>> hdl/gspd_if.sv
// Valid/ready channel interfaces for the decoder: line samples, keys and register writes.
// Depends on gspd_pkg for the payload widths.
`default_nettype none

interface gspd_in_if;
  logic valid;
  logic ready;
  logic line_level;
  modport source (output valid, output line_level, input ready);
  modport sink (input valid, input line_level, output ready);
endinterface

interface gspd_out_if import gspd_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic [LETTER_BITS-1:0] letter_code;
  logic [DIGIT_BITS-1:0]  digit;
  modport source (output valid, output letter_code, output digit, input ready);
  modport sink (input valid, input letter_code, input digit, output ready);
endinterface

interface gspd_cfg_if import gspd_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [REG_BITS-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/gspd_key_enc.sv
// Key encoder: turns the two group counts of a finished train into letter and digit.
// Depends on gspd_pkg for the key type and the letter constants.
`default_nettype none

module gspd_key_enc import gspd_pkg::*; #(
  parameter int COUNT_BITS = 6
) (
  input  wire logic [COUNT_BITS-1:0] first_cnt_i,
  input  wire logic [COUNT_BITS-1:0] second_cnt_i,
  output key_t                       key_o
);

  localparam int LW = (COUNT_BITS + 3 > 9) ? COUNT_BITS + 3 : 9;
  localparam int PW = COUNT_BITS + 8;
  localparam int QW = PW - 11;

  logic [COUNT_BITS-1:0] first;
  logic [COUNT_BITS-1:0] second;
  logic [LW-1:0]         lsum;
  logic [LW-1:0]         lskip;
  logic [PW-1:0]         prod;
  logic [QW-1:0]         quot;
  logic [COUNT_BITS-1:0] rem;

  always_comb begin
    first  = first_cnt_i - COUNT_BITS'(1);
    second = second_cnt_i - COUNT_BITS'(1);
    lsum   = LW'(LETTER_BASE) + LW'({second, 1'b0}) +
             LW'(first > COUNT_BITS'(DIGIT_RADIX));
    lskip  = (lsum > LW'(LETTER_SKIP)) ? lsum + LW'(1) : lsum;
    if (lskip > LW'(LETTER_MAX)) begin
      key_o.letter_code = LETTER_BITS'(LETTER_MAX);
    end else begin
      key_o.letter_code = lskip[LETTER_BITS-1:0];
    end
    // Division by ten through the reciprocal 205/2048, exact below 1029.
    prod        = PW'(first) * PW'(205);
    quot        = prod[PW-1:11];
    rem         = first - COUNT_BITS'(quot) * COUNT_BITS'(DIGIT_RADIX);
    key_o.digit = rem[DIGIT_BITS-1:0];
  end

endmodule

`default_nettype wire

>>> hdl/gap_split_pulse_train_decoder.sv
// Top level of the gap-split pulse train decoder: tick timer, group counters and result register.
// Depends on gspd_pkg, the channel interfaces in gspd_if and gspd_key_enc.
`default_nettype none

// One line sample is taken per cycle. A sample enters an input register, and when it advances
// out of it the timer, the group counters and the key encoder act on it and any key is written
// to the result register. The input side keeps taking a sample every cycle as long as the result
// register is empty or is taken in the same cycle; a key left waiting stalls the next sample.
// Register writes are taken in any cycle and should be made while no samples are in flight.
module gap_split_pulse_train_decoder import gspd_pkg::*; #(
  parameter int COUNT_BITS = 6,
  parameter int TIMER_BITS = 24
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  gspd_in_if.sink     in_i,
  gspd_cfg_if.sink    cfg_i,
  gspd_out_if.source  out_o
);

  localparam int CW = (TIMER_BITS > REG_BITS) ? TIMER_BITS : REG_BITS;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [REG_BITS-1:0]   jitter_q, gap_q, boundary_q;
  logic                  in_vld_q, level_q;
  logic                  prev_q, prev_d;
  logic [TIMER_BITS-1:0] elapsed_q, elapsed_d;
  logic                  grp_first_q, grp_first_d;
  logic [COUNT_BITS-1:0] first_q, first_d, second_q, second_d;
  logic                  out_vld_q, out_vld_d;
  key_t                  key_q, key_w;

  logic                  adv;
  logic                  emit;
  logic [TIMER_BITS-1:0] span;
  logic [CW-1:0]         span_w;

  gspd_key_enc #(.COUNT_BITS(COUNT_BITS)) u_key_enc (
    .first_cnt_i  (first_q),
    .second_cnt_i (second_q),
    .key_o        (key_w)
  );

  assign adv         = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || adv;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    span   = (elapsed_q < TIMER_MAX) ? elapsed_q + TIMER_BITS'(1) : TIMER_MAX;
    span_w = CW'(span);
    prev_d      = prev_q;
    elapsed_d   = elapsed_q;
    grp_first_d = grp_first_q;
    first_d     = first_q;
    second_d    = second_q;
    emit        = 1'b0;
    if (adv) begin
      if (span_w > CW'(boundary_q)) begin
        emit        = !grp_first_q && (first_q != '0) && (second_q != '0);
        first_d     = '0;
        second_d    = '0;
        grp_first_d = 1'b1;
      end
      if (level_q != prev_q) begin
        if (span_w > CW'(jitter_q)) begin
          if (grp_first_d && (span_w > CW'(gap_q)) && (span_w < CW'(boundary_q))) begin
            grp_first_d = 1'b0;
          end
          if (grp_first_d) begin
            first_d = (first_d < COUNT_MAX) ? first_d + COUNT_BITS'(1) : COUNT_MAX;
          end else begin
            second_d = (second_d < COUNT_MAX) ? second_d + COUNT_BITS'(1) : COUNT_MAX;
          end
        end
        elapsed_d = '0;
        prev_d    = level_q;
      end else begin
        elapsed_d = span;
      end
    end
    out_vld_d = adv ? emit : (out_vld_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jitter_q    <= JITTER_RESET;
      gap_q       <= GAP_RESET;
      boundary_q  <= BOUNDARY_RESET;
      in_vld_q    <= 1'b0;
      prev_q      <= 1'b0;
      elapsed_q   <= '0;
      grp_first_q <= 1'b1;
      first_q     <= '0;
      second_q    <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_JITTER:   jitter_q   <= cfg_i.data;
          CFG_GAP:      gap_q      <= cfg_i.data;
          CFG_BOUNDARY: boundary_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      prev_q      <= prev_d;
      elapsed_q   <= elapsed_d;
      grp_first_q <= grp_first_d;
      first_q     <= first_d;
      second_q    <= second_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      level_q <= in_i.line_level;
    end
    if (adv && emit) begin
      key_q <= key_w;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.letter_code = key_q.letter_code;
  assign out_o.digit       = key_q.digit;

endmodule

`default_nettype wire

>>> hdl/gspd_checker.sv
// Port-level checker for the decoder and the bind that attaches it to the top level.
// Depends on gspd_pkg for the field widths and letter constants.
`default_nettype none

module gspd_checker import gspd_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_ready_i,
  input wire logic                   out_valid_i,
  input wire logic                   out_ready_i,
  input wire logic [LETTER_BITS-1:0] letter_code_i,
  input wire logic [DIGIT_BITS-1:0]  digit_i
);

  // A key that is not taken stays offered with the same fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(letter_code_i) && $stable(digit_i))
    else $error("key changed or dropped while stalled");

  // The input side is only held back by a key that waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("input stalled without a waiting key");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> digit_i < DIGIT_BITS'(DIGIT_RADIX))
    else $error("digit out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (letter_code_i >= LETTER_BITS'(LETTER_BASE)) &&
                    (letter_code_i != LETTER_BITS'(LETTER_SKIP + 1)))
    else $error("letter code out of range or skipped letter");

endmodule

bind gap_split_pulse_train_decoder gspd_checker u_gspd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .letter_code_i (out_o.letter_code),
  .digit_i       (out_o.digit)
);

`default_nettype wire
